// File: sv/gcb_pkg.sv
`default_nettype none
package gcb_pkg;

	// Width of the signed coordinate arithmetic inside the draw sequencer.
	localparam int COORD_W   = 14;
	localparam int WORD_BITS = 16;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_DRAW = 1'b1;

	localparam logic [1:0] REG_CLIP_X      = 2'd0;
	localparam logic [1:0] REG_CLIP_Y      = 2'd1;
	localparam logic [1:0] REG_CLIP_WIDTH  = 2'd2;
	localparam logic [1:0] REG_CLIP_HEIGHT = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADDS,
		S_CLIP,
		S_BASE,
		S_ROW,
		S_FINAL
	} gcb_state_t;

	typedef struct packed {
		logic [10:0] clip_x;
		logic [10:0] clip_y;
		logic [11:0] clip_width;
		logic [11:0] clip_height;
	} gcb_clip_t;

	typedef struct packed {
		logic        is_row;
		logic [11:0] row_y;
		logic [11:0] first_x;
		logic [31:0] pixel_mask;
		logic [15:0] row_color;
		logic [7:0]  advance;
		logic        last;
	} gcb_result_t;

endpackage
`default_nettype wire

// File: sv/glyph_clip_blit.sv
`default_nettype none
// Clipped glyph blitter. Load items (func 0) write one 16-bit word of the glyph bitmap store,
// whose bits form a row-major pixel stream with a row stride equal to the saturated glyph
// width; a load gives no result. A draw item (func 1) places the glyph at pen plus offset,
// clips it to the non-negative quadrant and to the window set through the APB registers, and
// returns one result per visible row (row_y, first_x, a 32-bit mask of lit pixels and the ink
// color), then a final item with last set that carries the advance, or an advance of 0 when
// the pen lies right of or below the window. A draw works out the clipping arithmetic in its
// add, clip and base states, then reads three store words per row through the store's single
// read port; the next row's first read overlaps the current row's result, and the output side
// can hold a row until it is taken. The input side is not ready while a draw is in progress.
// Store words are not cleared at reset and must be loaded before a draw reads them.
// Registers: clip_x at byte 0, clip_y at 4, clip_width at 8 (reset 128), clip_height at 12
// (reset 64); write them only while the block is idle.
module glyph_clip_blit #(
	parameter int GLYPH_MAX_WIDTH  = 32,
	parameter int GLYPH_MAX_HEIGHT = 32,
	parameter int GLYPH_WORDS      = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [5:0]         word_index,
	input  wire logic [15:0]        word_data,
	input  wire logic signed [11:0] pen_x,
	input  wire logic signed [11:0] pen_y,
	input  wire logic signed [7:0]  bearing_x,
	input  wire logic signed [7:0]  bearing_y,
	input  wire logic [5:0]         glyph_width,
	input  wire logic [5:0]         glyph_height,
	input  wire logic [7:0]         glyph_advance,
	input  wire logic [15:0]        ink_color,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    is_row,
	output logic [11:0]             row_y,
	output logic [11:0]             first_x,
	output logic [31:0]             pixel_mask,
	output logic [15:0]             row_color,
	output logic [7:0]              advance,
	output logic                    last
);
	import gcb_pkg::*;

	// Read addresses span the bit stream's word range plus two words of overshoot.
	localparam int MEM_AW = $clog2(GLYPH_WORDS);
	localparam int NBITS  = $clog2(GLYPH_MAX_WIDTH * GLYPH_MAX_HEIGHT);
	localparam int RA_W   = (NBITS - 3 > MEM_AW) ? NBITS - 3 : MEM_AW;

	gcb_clip_t   cfg;
	logic        wr_en, rd_en;
	logic [5:0]  wr_index;
	logic [15:0] wr_data, rd_data;
	logic [RA_W-1:0] rd_addr;
	logic        out_free, emit_valid;
	gcb_result_t emit;
	gcb_result_t res_q;
	logic        out_valid_q;

	assign pready = 1'b1;

	gcb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	gcb_store #(
		.GLYPH_WORDS (GLYPH_WORDS),
		.RA_W        (RA_W)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	gcb_seq #(
		.GLYPH_MAX_WIDTH  (GLYPH_MAX_WIDTH),
		.GLYPH_MAX_HEIGHT (GLYPH_MAX_HEIGHT),
		.RA_W             (RA_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.word_index    (word_index),
		.word_data     (word_data),
		.pen_x         (pen_x),
		.pen_y         (pen_y),
		.bearing_x     (bearing_x),
		.bearing_y     (bearing_y),
		.glyph_width   (glyph_width),
		.glyph_height  (glyph_height),
		.glyph_advance (glyph_advance),
		.ink_color     (ink_color),
		.cfg           (cfg),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.out_free      (out_free),
		.emit_valid    (emit_valid),
		.emit          (emit)
	);

	// The output register takes a new item whenever it is empty or its item is leaving.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid && out_free) begin
			res_q <= emit;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_row     = res_q.is_row;
	assign row_y      = res_q.row_y;
	assign first_x    = res_q.first_x;
	assign pixel_mask = res_q.pixel_mask;
	assign row_color  = res_q.row_color;
	assign advance    = res_q.advance;
	assign last       = res_q.last;

endmodule
`default_nettype wire

// File: sv/gcb_regs.sv
`default_nettype none
module gcb_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output gcb_pkg::gcb_clip_t     cfg
);
	import gcb_pkg::*;

	gcb_clip_t  cfg_q;
	logic [1:0] reg_index;

	assign reg_index = paddr[3:2];
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_x      <= 11'd0;
			cfg_q.clip_y      <= 11'd0;
			cfg_q.clip_width  <= 12'd128;
			cfg_q.clip_height <= 12'd64;
		end else if (psel && penable && pwrite) begin
			case (reg_index)
				REG_CLIP_X:      cfg_q.clip_x      <= pwdata[10:0];
				REG_CLIP_Y:      cfg_q.clip_y      <= pwdata[10:0];
				REG_CLIP_WIDTH:  cfg_q.clip_width  <= pwdata[11:0];
				REG_CLIP_HEIGHT: cfg_q.clip_height <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_CLIP_X:      prdata = 32'(cfg_q.clip_x);
			REG_CLIP_Y:      prdata = 32'(cfg_q.clip_y);
			REG_CLIP_WIDTH:  prdata = 32'(cfg_q.clip_width);
			REG_CLIP_HEIGHT: prdata = 32'(cfg_q.clip_height);
			default:         prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// File: sv/gcb_store.sv
`default_nettype none
module gcb_store #(
	parameter int GLYPH_WORDS = 64,
	parameter int RA_W        = 7
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [5:0]      wr_index,
	input  wire logic [15:0]     wr_data,
	input  wire logic            rd_en,
	input  wire logic [RA_W-1:0] rd_addr,
	output logic      [15:0]     rd_data
);
	localparam int MEM_AW = $clog2(GLYPH_WORDS);
	localparam int WI_W   = (MEM_AW > 6) ? MEM_AW : 6;

	logic [15:0]     mem [GLYPH_WORDS];
	logic [15:0]     rd_data_q;
	logic [WI_W-1:0] wr_index_w;

	assign wr_index_w = WI_W'(wr_index);
	assign rd_data    = rd_data_q;

	// Words past the end of the store read as unlit pixels.
	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_index) < GLYPH_WORDS)) begin
			mem[wr_index_w[MEM_AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= (32'(rd_addr) < GLYPH_WORDS) ? mem[rd_addr[MEM_AW-1:0]] : 16'd0;
		end
	end

endmodule
`default_nettype wire

// File: sv/gcb_seq.sv
`default_nettype none
module gcb_seq #(
	parameter int GLYPH_MAX_WIDTH  = 32,
	parameter int GLYPH_MAX_HEIGHT = 32,
	parameter int RA_W             = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                func,
	input  wire logic [5:0]          word_index,
	input  wire logic [15:0]         word_data,
	input  wire logic signed [11:0]  pen_x,
	input  wire logic signed [11:0]  pen_y,
	input  wire logic signed [7:0]   bearing_x,
	input  wire logic signed [7:0]   bearing_y,
	input  wire logic [5:0]          glyph_width,
	input  wire logic [5:0]          glyph_height,
	input  wire logic [7:0]          glyph_advance,
	input  wire logic [15:0]         ink_color,
	input  gcb_pkg::gcb_clip_t       cfg,
	output logic                     wr_en,
	output logic [5:0]               wr_index,
	output logic [15:0]              wr_data,
	output logic                     rd_en,
	output logic [RA_W-1:0]          rd_addr,
	input  wire logic [15:0]         rd_data,
	input  wire logic                out_free,
	output logic                     emit_valid,
	output gcb_pkg::gcb_result_t     emit
);
	import gcb_pkg::*;

	localparam int NBITS = $clog2(GLYPH_MAX_WIDTH * GLYPH_MAX_HEIGHT);
	localparam int GW_W  = $clog2(GLYPH_MAX_WIDTH + 1);
	localparam int GH_W  = $clog2(GLYPH_MAX_HEIGHT + 1);
	localparam int RC_W  = GH_W;

	localparam logic [1:0] PH_RD0  = 2'd0;
	localparam logic [1:0] PH_RD1  = 2'd1;
	localparam logic [1:0] PH_RD2  = 2'd2;
	localparam logic [1:0] PH_FORM = 2'd3;

	gcb_state_t state_q, state_d;

	logic signed [11:0]        px_q, py_q;
	logic signed [7:0]         ol_q, ot_q;
	logic [GW_W-1:0]           gw_q;
	logic [GH_W-1:0]           gh_q;
	logic [7:0]                adv_q;
	logic [15:0]               color_q;
	logic signed [COORD_W-1:0] x_q, y_q, right_q, bottom_q;
	logic signed [COORD_W-1:0] outx_q, outy_q, maxx_q, maxy_q;
	logic                      reject_q;
	logic [NBITS-1:0]          n0_q;
	logic [31:0]               colmask_q;
	logic [RC_W-1:0]           rows_left_q;
	logic [11:0]               rowy_q;
	logic [1:0]                phase_q;
	logic [15:0]               w0_q, w1_q;

	logic                      draw_acc;
	logic signed [COORD_W-1:0] pxe, pye, clipx_s, clipy_s, gwe, ghe;
	logic signed [COORD_W-1:0] xend, yend, ncols, gx0, gy0;
	logic                      reject_w, visible_w, last_row, row_fire;
	logic [GW_W+GH_W-1:0]      prod_w;
	logic [6:0]                nc7;
	logic [31:0]               colmask_w;
	logic [NBITS-1:0]          n0_next, base_n;
	logic [NBITS-5:0]          word_w;
	logic [1:0]                word_off;
	logic [47:0]               row_bits;
	logic [47:0]               row_shift;

	assign draw_acc = in_valid && (state_q == S_IDLE) && (func == FUNC_DRAW);

	assign pxe     = COORD_W'(px_q);
	assign pye     = COORD_W'(py_q);
	assign clipx_s = $signed(COORD_W'(cfg.clip_x));
	assign clipy_s = $signed(COORD_W'(cfg.clip_y));
	assign gwe     = $signed(COORD_W'(gw_q));
	assign ghe     = $signed(COORD_W'(gh_q));
	assign xend    = x_q + gwe;
	assign yend    = y_q + ghe;
	assign reject_w  = (pxe > right_q) || (pye > bottom_q);
	assign visible_w = (outx_q < maxx_q) && (outy_q < maxy_q);

	// Start bit of the first visible row: stride times skipped rows plus skipped columns.
	assign ncols  = maxx_q - outx_q;
	assign gx0    = outx_q - x_q;
	assign gy0    = outy_q - y_q;
	assign prod_w = gw_q * gy0[GH_W-1:0];
	assign nc7    = ncols[6:0];
	assign colmask_w = (nc7 >= 7'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << nc7[4:0]);

	assign last_row = (rows_left_q == RC_W'(1));
	assign row_fire = (state_q == S_ROW) && (phase_q == PH_FORM) && out_free;
	assign n0_next  = n0_q + NBITS'(gw_q);
	assign base_n   = (phase_q == PH_FORM) ? n0_next : n0_q;
	assign word_w   = base_n[NBITS-1:4];
	assign word_off = (phase_q == PH_FORM) ? PH_RD0 : phase_q;

	assign row_bits  = {rd_data, w1_q, w0_q};
	assign row_shift = row_bits >> n0_q[3:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (draw_acc) state_d = S_ADDS;
			S_ADDS:  state_d = S_CLIP;
			S_CLIP:  state_d = reject_w ? S_FINAL : S_BASE;
			S_BASE:  state_d = visible_w ? S_ROW : S_FINAL;
			S_ROW:   if (row_fire && last_row) state_d = S_FINAL;
			S_FINAL: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		wr_en      = in_valid && (state_q == S_IDLE) && (func == FUNC_LOAD);
		wr_index   = word_index;
		wr_data    = word_data;
		rd_en      = 1'b0;
		rd_addr    = RA_W'(word_w) + RA_W'(word_off);
		emit_valid = 1'b0;
		emit       = '0;
		case (state_q)
			S_ROW: begin
				rd_en = (phase_q != PH_FORM) || (out_free && !last_row);
				if (phase_q == PH_FORM) begin
					emit_valid      = 1'b1;
					emit.is_row     = 1'b1;
					emit.row_y      = rowy_q;
					emit.first_x    = outx_q[11:0];
					emit.pixel_mask = row_shift[31:0] & colmask_q;
					emit.row_color  = color_q;
				end
			end
			S_FINAL: begin
				emit_valid   = 1'b1;
				emit.advance = reject_q ? 8'd0 : adv_q;
				emit.last    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			reject_q    <= 1'b0;
			phase_q     <= PH_RD0;
			rows_left_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLIP: reject_q <= reject_w;
				S_BASE: begin
					rows_left_q <= RC_W'(maxy_q - outy_q);
					phase_q     <= PH_RD0;
				end
				S_ROW: begin
					if (phase_q != PH_FORM) begin
						phase_q <= phase_q + 2'd1;
					end else if (out_free && !last_row) begin
						// The next row's first word is already being read.
						phase_q     <= PH_RD1;
						rows_left_q <= rows_left_q - RC_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (draw_acc) begin
					px_q    <= pen_x;
					py_q    <= pen_y;
					ol_q    <= bearing_x;
					ot_q    <= bearing_y;
					gw_q    <= (32'(glyph_width) > GLYPH_MAX_WIDTH) ?
						GW_W'(GLYPH_MAX_WIDTH) : GW_W'(glyph_width);
					gh_q    <= (32'(glyph_height) > GLYPH_MAX_HEIGHT) ?
						GH_W'(GLYPH_MAX_HEIGHT) : GH_W'(glyph_height);
					adv_q   <= glyph_advance;
					color_q <= ink_color;
				end
			end
			S_ADDS: begin
				x_q      <= pxe + COORD_W'(ol_q);
				y_q      <= pye + COORD_W'(ot_q);
				right_q  <= $signed(COORD_W'(cfg.clip_x) + COORD_W'(cfg.clip_width));
				bottom_q <= $signed(COORD_W'(cfg.clip_y) + COORD_W'(cfg.clip_height));
			end
			S_CLIP: begin
				outx_q <= (x_q > clipx_s) ? x_q : clipx_s;
				outy_q <= (y_q > clipy_s) ? y_q : clipy_s;
				maxx_q <= (xend > right_q) ? right_q : xend;
				maxy_q <= (yend > bottom_q) ? bottom_q : yend;
			end
			S_BASE: begin
				n0_q      <= NBITS'(prod_w) + NBITS'(gx0);
				colmask_q <= colmask_w;
				rowy_q    <= outy_q[11:0];
			end
			S_ROW: begin
				if (phase_q == PH_RD1) w0_q <= rd_data;
				if (phase_q == PH_RD2) w1_q <= rd_data;
				if (row_fire && !last_row) begin
					n0_q   <= n0_next;
					rowy_q <= rowy_q + 12'd1;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: dv/glyph_clip_blit_tb.sv
`timescale 1ns / 1ps

module glyph_clip_blit_tb;
	import gcb_pkg::*;

	localparam int GLYPH_MAX_W  = 32;
	localparam int GLYPH_MAX_H  = 32;
	localparam int STORE_WORDS  = 64;
	localparam int RUN_LIMIT    = 600000;
	localparam int REPORT_LIMIT = 10;
	// This margin covers a load still being written before any register write.
	localparam int IDLE_MARGIN  = 8;
	localparam int HOLD_CYCLES  = 600;

	// One input item as the sender presents it. Signed fields are kept as raw bits and
	// reinterpreted with $signed wherever the arithmetic needs it.
	typedef struct packed {
		logic        func;
		logic [5:0]  word_index;
		logic [15:0] word_data;
		logic [11:0] pen_x;
		logic [11:0] pen_y;
		logic [7:0]  bearing_x;
		logic [7:0]  bearing_y;
		logic [5:0]  glyph_width;
		logic [5:0]  glyph_height;
		logic [7:0]  glyph_advance;
		logic [15:0] ink_color;
	} glyph_item_t;

	logic clk;
	logic arst_n;

	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic               in_valid;
	logic               in_ready;
	logic               func;
	logic [5:0]         word_index;
	logic [15:0]        word_data;
	logic signed [11:0] pen_x;
	logic signed [11:0] pen_y;
	logic signed [7:0]  bearing_x;
	logic signed [7:0]  bearing_y;
	logic [5:0]         glyph_width;
	logic [5:0]         glyph_height;
	logic [7:0]         glyph_advance;
	logic [15:0]        ink_color;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        is_row;
	logic [11:0] row_y;
	logic [11:0] first_x;
	logic [31:0] pixel_mask;
	logic [15:0] row_color;
	logic [7:0]  advance;
	logic        last;

	// Shadow copies of the block's state: the clip window and the glyph bitmap store.
	gcb_clip_t   window;
	logic [15:0] glyph_store [STORE_WORDS];

	// Row writes and advance reports that the block still owes, oldest first.
	gcb_result_t due_results [$];

	int error_count;
	int cycle_count = 0;
	int send_idle_pct;
	int recv_stall_pct;
	logic out_hold;

	glyph_clip_blit #(
		.GLYPH_MAX_WIDTH (GLYPH_MAX_W),
		.GLYPH_MAX_HEIGHT(GLYPH_MAX_H),
		.GLYPH_WORDS     (STORE_WORDS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.word_index   (word_index),
		.word_data    (word_data),
		.pen_x        (pen_x),
		.pen_y        (pen_y),
		.bearing_x    (bearing_x),
		.bearing_y    (bearing_y),
		.glyph_width  (glyph_width),
		.glyph_height (glyph_height),
		.glyph_advance(glyph_advance),
		.ink_color    (ink_color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_row       (is_row),
		.row_y        (row_y),
		.first_x      (first_x),
		.pixel_mask   (pixel_mask),
		.row_color    (row_color),
		.advance      (advance),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Any run that is still going at this point has hung somewhere; the limit is several
	// times the slowest legal run, tall glyphs and long receiver stalls included.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Works out the results of one accepted draw and queues them. The glyph lands at pen
	// plus offset, is clipped to the non-negative quadrant and to the window, and each
	// visible row gives one row write. The closing report carries the advance, or zero
	// when the pen itself lies right of or below the window.
	function automatic void trace_draw(input glyph_item_t it);
		int right, bottom, px, py, gw, gh;
		int x, y, maxx, maxy, gx0, gy0, outx, outy, n, r, c;
		logic [31:0] mask;
		gcb_result_t res;
		right  = int'(window.clip_x) + int'(window.clip_width);
		bottom = int'(window.clip_y) + int'(window.clip_height);
		px = $signed(it.pen_x);
		py = $signed(it.pen_y);
		res = '0;
		res.last = 1'b1;
		if (px > right || py > bottom) begin
			due_results.push_back(res);
			return;
		end
		// Oversized glyphs saturate, and the saturated width is also the row stride.
		gw = int'(it.glyph_width);
		gh = int'(it.glyph_height);
		if (gw > GLYPH_MAX_W) gw = GLYPH_MAX_W;
		if (gh > GLYPH_MAX_H) gh = GLYPH_MAX_H;
		x = px + $signed(it.bearing_x);
		y = py + $signed(it.bearing_y);
		maxx = x + gw;
		maxy = y + gh;
		gx0 = 0;
		gy0 = 0;
		if (x < 0) begin
			gx0 = -x;
			x = 0;
		end
		if (y < 0) begin
			gy0 = -y;
			y = 0;
		end
		if (maxx > right) maxx = right;
		if (maxy > bottom) maxy = bottom;
		outx = (x > int'(window.clip_x)) ? x : int'(window.clip_x);
		outy = (y > int'(window.clip_y)) ? y : int'(window.clip_y);
		gx0 += outx - x;
		gy0 += outy - y;
		if (maxx > 0 && maxy > 0 && outx < maxx && outy < maxy) begin
			for (r = 0; outy + r < maxy; r++) begin
				mask = '0;
				for (c = 0; outx + c < maxx; c++) begin
					n = gw * (gy0 + r) + gx0 + c;
					// Pixels whose word lies past the store stay dark, and so do
					// columns past the 32 bits of the mask.
					if (c < 32 && n / WORD_BITS < STORE_WORDS &&
					    glyph_store[n / WORD_BITS][n % WORD_BITS])
						mask[c] = 1'b1;
				end
				res = '0;
				res.is_row     = 1'b1;
				res.row_y      = outy[11:0] + r[11:0];
				res.first_x    = outx[11:0];
				res.pixel_mask = mask;
				res.row_color  = it.ink_color;
				due_results.push_back(res);
			end
		end
		// An empty or fully clipped glyph still reports its advance.
		res = '0;
		res.advance = it.glyph_advance;
		res.last    = 1'b1;
		due_results.push_back(res);
	endfunction

	// Every field gets fresh random bits, so fields that the operation ignores still
	// toggle through both values.
	function automatic glyph_item_t random_fields();
		glyph_item_t it;
		logic [31:0] a, b, d;
		a = $urandom;
		b = $urandom;
		d = $urandom;
		it.func          = a[0];
		it.word_index    = a[6:1];
		it.word_data     = a[22:7];
		it.pen_x         = b[11:0];
		it.pen_y         = b[23:12];
		it.bearing_x     = b[31:24];
		it.bearing_y     = d[7:0];
		it.glyph_width   = d[13:8];
		it.glyph_height  = d[19:14];
		it.glyph_advance = d[27:20];
		a = $urandom;
		it.ink_color     = a[15:0];
		return it;
	endfunction

	function automatic glyph_item_t load_item(input int idx, input logic [15:0] data);
		glyph_item_t it;
		it = random_fields();
		it.func       = FUNC_LOAD;
		it.word_index = idx[5:0];
		it.word_data  = data;
		return it;
	endfunction

	function automatic glyph_item_t draw_item(input int px, input int py, input int ol,
	                                          input int ot, input int w, input int h,
	                                          input int adv, input int color);
		glyph_item_t it;
		it = random_fields();
		it.func          = FUNC_DRAW;
		it.pen_x         = px[11:0];
		it.pen_y         = py[11:0];
		it.bearing_x     = ol[7:0];
		it.bearing_y     = ot[7:0];
		it.glyph_width   = w[5:0];
		it.glyph_height  = h[5:0];
		it.glyph_advance = adv[7:0];
		it.ink_color     = color[15:0];
		return it;
	endfunction

	function automatic logic [11:0] clamp_coord(input int v);
		int t;
		t = v;
		if (t > 2047) t = 2047;
		if (t < -2048) t = -2048;
		return t[11:0];
	endfunction

	// Most random draws are aimed at the current window with small offsets and sizes, so
	// that they really clip and emit rows; the rest keep fully random fields as noise.
	function automatic glyph_item_t aimed_draw();
		glyph_item_t it;
		int span_x, span_y, px, py, t;
		it = random_fields();
		it.func = FUNC_DRAW;
		if ($urandom_range(99) < 80) begin
			span_x = (window.clip_width > 12'd200) ? 200 : int'(window.clip_width);
			span_y = (window.clip_height > 12'd200) ? 200 : int'(window.clip_height);
			px = int'(window.clip_x) - 24 + int'($urandom_range(0, span_x + 30));
			py = int'(window.clip_y) - 24 + int'($urandom_range(0, span_y + 30));
			it.pen_x = clamp_coord(px);
			it.pen_y = clamp_coord(py);
			t = int'($urandom_range(0, 16)) - 8;
			it.bearing_x = t[7:0];
			t = int'($urandom_range(0, 16)) - 8;
			it.bearing_y = t[7:0];
			if ($urandom_range(9) != 0) begin
				t = int'($urandom_range(0, 20));
				it.glyph_width = t[5:0];
				t = int'($urandom_range(0, 20));
				it.glyph_height = t[5:0];
			end
		end
		return it;
	endfunction

	// Presents one item and holds it until the block takes it. The predictor is updated at
	// the accepting edge. The sender may then go quiet for a random stretch; otherwise
	// valid simply stays high for the next item.
	task automatic offer_item(input glyph_item_t it);
		func          <= it.func;
		word_index    <= it.word_index;
		word_data     <= it.word_data;
		pen_x         <= it.pen_x;
		pen_y         <= it.pen_y;
		bearing_x     <= it.bearing_x;
		bearing_y     <= it.bearing_y;
		glyph_width   <= it.glyph_width;
		glyph_height  <= it.glyph_height;
		glyph_advance <= it.glyph_advance;
		ink_color     <= it.ink_color;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (it.func == FUNC_LOAD)
			glyph_store[it.word_index] = it.word_data;
		else
			trace_draw(it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Brings the block to rest: nothing offered, nothing owed, and a few spare cycles in
	// case a load is still being written.
	task automatic drain_and_idle();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (IDLE_MARGIN) @(posedge clk);
	endtask

	// One APB write: setup cycle, then the access cycle in which the register takes the data.
	// The leading edge keeps psel low for a cycle between back-to-back writes.
	task automatic write_clip_reg(input logic [1:0] reg_idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_idx)
			REG_CLIP_X:      window.clip_x      = value[10:0];
			REG_CLIP_Y:      window.clip_y      = value[10:0];
			REG_CLIP_WIDTH:  window.clip_width  = value[11:0];
			REG_CLIP_HEIGHT: window.clip_height = value[11:0];
			default: ;
		endcase
	endtask

	task automatic set_window(input int cx, input int cy, input int cw, input int ch);
		drain_and_idle();
		write_clip_reg(REG_CLIP_X, cx);
		write_clip_reg(REG_CLIP_Y, cy);
		write_clip_reg(REG_CLIP_WIDTH, cw);
		write_clip_reg(REG_CLIP_HEIGHT, ch);
	endtask

	// Every store word is written before the first draw, since the block leaves the store
	// undefined at reset. Word 0 starts all lit and the top word all dark.
	task automatic test_store_fill();
		logic [31:0] bits;
		int i;
		for (i = 0; i < STORE_WORDS; i++) begin
			bits = $urandom;
			if (i == 0) bits[15:0] = 16'hFFFF;
			if (i == STORE_WORDS - 1) bits[15:0] = 16'h0000;
			offer_item(load_item(i, bits[15:0]));
		end
	endtask

	// Hand-picked draws under the reset window (0, 0, 128 x 64).
	task automatic test_draw_cases();
		offer_item(draw_item(10, 10, 0, 0, 8, 8, 8, 16'h1234));
		// Zero width and zero height: only the advance report comes back.
		offer_item(draw_item(20, 4, 2, -3, 0, 6, 5, 16'h00FF));
		offer_item(draw_item(20, 4, 0, 0, 7, 0, 6, 16'hFF00));
		// Pen right of the window, then below it: the draw is rejected with advance 0.
		offer_item(draw_item(129, 10, 0, 0, 8, 8, 9, 16'hAAAA));
		offer_item(draw_item(10, 65, 0, 0, 8, 8, 9, 16'h5555));
		// Pen exactly on the far corner is not rejected, but nothing is visible.
		offer_item(draw_item(128, 64, 0, 0, 8, 8, 11, 16'h0F0F));
		// Most negative pen and offsets: fully clipped against the quadrant.
		offer_item(draw_item(-2048, -2048, -128, -128, 32, 32, 12, 16'hF0F0));
		// Partly above and left of the origin.
		offer_item(draw_item(-5, -3, 0, 0, 16, 16, 13, 16'h1357));
		// Oversized glyph saturates to the maximum width and height.
		offer_item(draw_item(20, 20, 0, 0, 63, 63, 14, 16'h2468));
		// Only one column survives at the right edge.
		offer_item(draw_item(0, 0, 127, 0, 32, 4, 15, 16'h3C3C));
		// Runs off the right and bottom edges; then a pen far outside the window is rejected.
		offer_item(draw_item(100, 60, 0, 0, 32, 32, 16, 16'hC3C3));
		offer_item(draw_item(2047, 2047, 127, 127, 32, 32, 17, 16'h7777));
		// Whole glyph at the origin with the largest advance and color.
		offer_item(draw_item(0, 0, 0, 0, 32, 32, 255, 16'hFFFF));
		// Offsets pull the glyph out of view: the report carries the zero advance.
		offer_item(draw_item(30, 30, -128, -128, 32, 32, 0, 16'h0000));
		offer_item(draw_item(40, 40, 3, -20, 31, 17, 18, 16'h8001));
	endtask

	// Window extremes: far corner of the coordinate range, an empty window, and a small
	// window with glyphs straddling each of its edges.
	task automatic test_clip_window();
		set_window(2047, 2047, 2048, 2048);
		offer_item(draw_item(2047, 2047, -10, -5, 32, 32, 21, 16'h4321));
		offer_item(draw_item(-2048, -2048, 127, 127, 32, 32, 22, 16'h8765));
		set_window(2047, 2047, 0, 0);
		offer_item(draw_item(2047, 2047, 0, 0, 8, 8, 23, 16'hABCD));
		offer_item(draw_item(2047, 2040, 0, 0, 8, 8, 24, 16'hDCBA));
		set_window(0, 0, 0, 0);
		offer_item(draw_item(0, 0, 0, 0, 4, 4, 25, 16'h0001));
		offer_item(draw_item(1, 0, 0, 0, 4, 4, 26, 16'h8000));
		set_window(100, 50, 40, 30);
		offer_item(draw_item(95, 45, 0, 0, 16, 16, 27, 16'h1111));
		offer_item(draw_item(135, 75, 0, 0, 16, 16, 28, 16'h2222));
		offer_item(draw_item(141, 10, 0, 0, 16, 16, 29, 16'h3333));
	endtask

	// Random traffic in four idling phases: none, a slow sender, a slow receiver, and both.
	// Each phase gets its own random window. About one item in five reloads a store word.
	task automatic test_random_traffic();
		int phase, i;
		int send_pct [4];
		int recv_pct [4];
		send_pct = '{0, 53, 0, 20};
		recv_pct = '{0, 0, 53, 20};
		for (phase = 0; phase < 4; phase++) begin
			set_window($urandom_range(0, 300), $urandom_range(0, 300),
			           $urandom_range(1, 160), $urandom_range(1, 100));
			send_idle_pct  = send_pct[phase];
			recv_stall_pct = recv_pct[phase];
			for (i = 0; i < 9; i++) begin
				if ($urandom_range(99) < 20)
					offer_item(load_item($urandom_range(0, STORE_WORDS - 1),
					                     16'($urandom)));
				else
					offer_item(aimed_draw());
			end
		end
	endtask

	// The receiver refuses everything for a long stretch while tall draws keep coming, so
	// the block backs up and has to stall its input until the hold-off ends.
	task automatic test_backpressure();
		int i;
		set_window(0, 0, 128, 64);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fork
			begin
				out_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_hold <= 1'b0;
			end
		join_none
		for (i = 0; i < 6; i++)
			offer_item(draw_item(10 + i, 5, 0, 0, 32, 32, 40 + i, 16'h6000 + i));
	endtask

	task automatic note_error(input string what, input gcb_result_t want,
	                          input gcb_result_t got);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%0t %s: expected row=%0b y=%0d x=%0d mask=%h color=%h adv=%0d last=%0b,",
			         $realtime, what, want.is_row, want.row_y, want.first_x,
			         want.pixel_mask, want.row_color, want.advance, want.last,
			         " got row=%0b y=%0d x=%0d mask=%h color=%h adv=%0d last=%0b",
			         got.is_row, got.row_y, got.first_x, got.pixel_mask, got.row_color,
			         got.advance, got.last);
	endtask

	// Result side: every accepted result is matched against the oldest owed one, and the
	// ready line is redrawn each cycle unless the long hold-off is in force.
	always @(posedge clk) begin : result_check
		gcb_result_t got;
		gcb_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {is_row, row_y, first_x, pixel_mask, row_color, advance, last};
			if (due_results.size() == 0) begin
				note_error("unexpected result", '0, got);
			end else begin
				want = due_results.pop_front();
				if (got.is_row !== want.is_row || got.row_y !== want.row_y ||
				    got.first_x !== want.first_x || got.pixel_mask !== want.pixel_mask ||
				    got.row_color !== want.row_color || got.advance !== want.advance ||
				    got.last !== want.last)
					note_error("result mismatch", want, got);
			end
		end
		out_ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		func           = FUNC_LOAD;
		word_index     = '0;
		word_data      = '0;
		pen_x          = '0;
		pen_y          = '0;
		bearing_x      = '0;
		bearing_y      = '0;
		glyph_width    = '0;
		glyph_height   = '0;
		glyph_advance  = '0;
		ink_color      = '0;
		out_hold       = 1'b0;
		error_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		window.clip_x      = 11'd0;
		window.clip_y      = 11'd0;
		window.clip_width  = 12'd128;
		window.clip_height = 12'd64;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_store_fill();
		test_draw_cases();
		test_clip_window();
		test_random_traffic();
		test_backpressure();

		// Everything owed has to arrive; then a quiet stretch catches any stray result.
		drain_and_idle();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
sv/gcb_pkg.sv
sv/gcb_regs.sv
sv/gcb_store.sv
sv/gcb_seq.sv
sv/glyph_clip_blit.sv
dv/glyph_clip_blit_tb.sv
